// ----- hw/rtl/assert_macros.svh -----
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define BWR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define BWR_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BWR_ASSERT_IMP(lbl, ante, cons, msg)
`define BWR_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ----- hw/rtl/bwr_pkg.sv -----
// types, constants and arithmetic helpers of the buoyancy wrench core
package bwr_pkg;

	localparam int DIV_STEPS = 32;
	localparam logic [19:0] GRAVITY_Q16 = 20'd642908;

	typedef enum logic [2:0] {
		CFG_COMP_RATIO,
		CFG_ADD_FX,
		CFG_ADD_FY,
		CFG_ADD_FZ,
		CFG_OFF_X,
		CFG_OFF_Y,
		CFG_OFF_Z,
		CFG_HEIGHT_LIMIT
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_SAT        = 2'd1,
		ST_LIMIT_ZERO = 2'd2
	} status_t;

	typedef struct packed {
		logic valid;
		logic above;
		logic full;
	} div_ctl_t;

	typedef struct packed {
		logic               clip;
		logic signed [31:0] val;
	} sat_t;

	function automatic sat_t sat32(input logic signed [56:0] v);
		sat_t r;
		r.clip = !((&v[56:31]) || (~|v[56:31]));
		if (r.clip) begin
			r.val = v[56] ? 32'sh80000000 : 32'sh7fffffff;
		end else begin
			r.val = v[31:0];
		end
		return r;
	endfunction

	// floor(a*b / 2^30) on q2.30 quaternion parts
	function automatic logic signed [33:0] mul_q30(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p[63:30];
	endfunction

	function automatic logic signed [37:0] mul_rot(input logic signed [35:0] r,
			input logic signed [31:0] o);
		logic signed [67:0] p;
		p = 68'(r) * 68'(o);
		return p[67:30];
	endfunction

	function automatic logic signed [39:0] mul_scale(input logic signed [38:0] f,
			input logic [31:0] s);
		logic signed [71:0] p;
		p = 72'(f) * 72'(signed'({1'b0, s}));
		return p[71:32];
	endfunction

	function automatic logic signed [55:0] mul_mom(input logic signed [39:0] o,
			input logic signed [31:0] f);
		logic signed [71:0] p;
		p = 72'(o) * 72'(f);
		return p[71:16];
	endfunction

endpackage

// ----- hw/rtl/bwr_scale_div.sv -----
// pipelined restoring divider for the depth scale, one quotient bit per stage
module bwr_scale_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  bwr_pkg::div_ctl_t   ctl_in,
	input  logic [31:0]         d_in,
	input  logic [30:0]         lim,
	output bwr_pkg::div_ctl_t   ctl_out,
	output logic [31:0]         scale
);

	bwr_pkg::div_ctl_t ctl_s [1:bwr_pkg::DIV_STEPS];
	logic [31:0]       rem_s [1:bwr_pkg::DIV_STEPS];
	logic [31:0]       q_s   [1:bwr_pkg::DIV_STEPS];

	for (genvar i = 0; i < bwr_pkg::DIV_STEPS; i++) begin : g_step
		bwr_pkg::div_ctl_t ctl_prev;
		logic [31:0]       q_prev;
		logic [31:0]       trial;
		logic              geq;

		if (i == 0) begin : g_first
			assign ctl_prev = ctl_in;
			assign q_prev   = '0;
			assign trial    = d_in;
		end else begin : g_rest
			assign ctl_prev = ctl_s[i];
			assign q_prev   = q_s[i];
			assign trial    = {rem_s[i][30:0], 1'b0};
		end

		assign geq = trial >= {1'b0, lim};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else if (en) begin
				ctl_s[i+1] <= ctl_prev;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= geq ? trial - {1'b0, lim} : trial;
				q_s[i+1]   <= {q_prev[30:0], geq};
			end
		end
	end

	assign ctl_out = ctl_s[bwr_pkg::DIV_STEPS];
	assign scale   = ctl_s[bwr_pkg::DIV_STEPS].above ? '0 : q_s[bwr_pkg::DIV_STEPS];

endmodule

// ----- hw/rtl/buoyancy_wrench_core.sv -----
// top level of the buoyancy wrench core
// One body per transaction, one transaction per clock when the output is taken. The pipeline
// has five stages of quaternion, rotation and force arithmetic, a 32-stage restoring
// divider that produces one bit of the depth scale per stage, and four stages of scaling,
// saturation and moment products. A stalled output freezes the whole pipeline. Registers
// are taken from cfg_* at any time, with ready always high; they are read live by the stages
// that use them, so write them only while no transaction is in flight.
`include "assert_macros.svh"

module buoyancy_wrench_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [30:0]        link_mass,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] quat_w,
	input  logic signed [31:0] quat_x,
	input  logic signed [31:0] quat_y,
	input  logic signed [31:0] quat_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] force_x,
	output logic signed [31:0] force_y,
	output logic signed [31:0] force_z,
	output logic signed [31:0] moment_x,
	output logic signed [31:0] moment_y,
	output logic signed [31:0] moment_z,
	output logic [1:0]         status
);

	logic [18:0]        comp_q;
	logic signed [31:0] afx_q, afy_q, afz_q;
	logic signed [31:0] off_q [3];
	logic [30:0]        lim_q;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s9;
	logic v_s6, v_s7, v_s8;

	logic signed [33:0] ww_s1, xx_s1, yy_s1, zz_s1, xy_s1;
	logic signed [33:0] xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	logic [33:0]        bm_s1;
	logic signed [31:0] pz_s1, pz_s2, pz_s3, pz_s4;
	logic [49:0]        mass_prod;

	logic signed [35:0] r_s2 [3][3];
	logic signed [38:0] fz_s2, fz_s3, fz_s4, fz_s5;
	logic [53:0]        grav_prod;

	logic signed [37:0] ro_s3 [3][3];
	logic signed [39:0] o_s4 [3];
	logic signed [39:0] o_s5 [3];

	logic signed [40:0] cz;
	logic signed [41:0] lim_ext, dd;
	bwr_pkg::div_ctl_t  ctl_s5, ctl_d;
	logic [31:0]        d_s5, scale_d;

	logic signed [38:0] fz_dly_s [1:bwr_pkg::DIV_STEPS];
	logic signed [39:0] o_dly_s  [1:bwr_pkg::DIV_STEPS][3];

	logic signed [38:0] fv [3];
	logic signed [39:0] v_f_s6 [3];
	logic signed [39:0] o_s6 [3], o_s7 [3];
	logic signed [31:0] f_s7 [3], f_s8 [3];
	logic               clip_s7, clip_s8;
	logic signed [55:0] mt_s8 [6];
	bwr_pkg::sat_t      fsat [3];
	bwr_pkg::sat_t      msat [3];

	logic signed [31:0] f_s9 [3];
	logic signed [31:0] m_s9 [3];
	bwr_pkg::status_t   status_s9;

	assign cfg_ready = 1'b1;
	assign en        = !(v_s9 && out_stall);
	assign in_stall  = v_s9 && out_stall;
	assign out_valid = v_s9;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_q <= 19'd65536;
			afx_q  <= '0;
			afy_q  <= '0;
			afz_q  <= '0;
			off_q  <= '{default: '0};
			lim_q  <= 31'd65536;
		end else if (cfg_valid && cfg_ready) begin
			case (bwr_pkg::cfg_idx_t'(cfg_index))
				bwr_pkg::CFG_COMP_RATIO:   comp_q   <= cfg_data[18:0];
				bwr_pkg::CFG_ADD_FX:       afx_q    <= cfg_data;
				bwr_pkg::CFG_ADD_FY:       afy_q    <= cfg_data;
				bwr_pkg::CFG_ADD_FZ:       afz_q    <= cfg_data;
				bwr_pkg::CFG_OFF_X:        off_q[0] <= cfg_data;
				bwr_pkg::CFG_OFF_Y:        off_q[1] <= cfg_data;
				bwr_pkg::CFG_OFF_Z:        off_q[2] <= cfg_data;
				bwr_pkg::CFG_HEIGHT_LIMIT: lim_q    <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s6 <= ctl_d.valid;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
			v_s9 <= v_s8;
		end
	end

	// stage 1: quaternion products and mass times compensation
	assign mass_prod = link_mass * comp_q;

	always_ff @(posedge clk) begin
		if (en) begin
			ww_s1 <= bwr_pkg::mul_q30(quat_w, quat_w);
			xx_s1 <= bwr_pkg::mul_q30(quat_x, quat_x);
			yy_s1 <= bwr_pkg::mul_q30(quat_y, quat_y);
			zz_s1 <= bwr_pkg::mul_q30(quat_z, quat_z);
			xy_s1 <= bwr_pkg::mul_q30(quat_x, quat_y);
			xz_s1 <= bwr_pkg::mul_q30(quat_x, quat_z);
			yz_s1 <= bwr_pkg::mul_q30(quat_y, quat_z);
			wx_s1 <= bwr_pkg::mul_q30(quat_w, quat_x);
			wy_s1 <= bwr_pkg::mul_q30(quat_w, quat_y);
			wz_s1 <= bwr_pkg::mul_q30(quat_w, quat_z);
			bm_s1 <= mass_prod[49:16];
			pz_s1 <= pos_z;
		end
	end

	// stage 2: rotation matrix and vertical force
	assign grav_prod = bm_s1 * bwr_pkg::GRAVITY_Q16;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s2[0][0] <= 36'(ww_s1) + 36'(xx_s1) - 36'(yy_s1) - 36'(zz_s1);
			r_s2[0][1] <= (36'(xy_s1) - 36'(wz_s1)) <<< 1;
			r_s2[0][2] <= (36'(xz_s1) + 36'(wy_s1)) <<< 1;
			r_s2[1][0] <= (36'(xy_s1) + 36'(wz_s1)) <<< 1;
			r_s2[1][1] <= 36'(ww_s1) - 36'(xx_s1) + 36'(yy_s1) - 36'(zz_s1);
			r_s2[1][2] <= (36'(yz_s1) - 36'(wx_s1)) <<< 1;
			r_s2[2][0] <= (36'(xz_s1) - 36'(wy_s1)) <<< 1;
			r_s2[2][1] <= (36'(yz_s1) + 36'(wx_s1)) <<< 1;
			r_s2[2][2] <= 36'(ww_s1) - 36'(xx_s1) - 36'(yy_s1) + 36'(zz_s1);
			fz_s2      <= 39'(afz_q) + signed'({1'b0, grav_prod[53:16]});
			pz_s2      <= pz_s1;
		end
	end

	// stage 3: matrix times offset
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					ro_s3[i][j] <= bwr_pkg::mul_rot(r_s2[i][j], off_q[j]);
				end
			end
			fz_s3 <= fz_s2;
			pz_s3 <= pz_s2;
		end
	end

	// stage 4: rotated offset
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				o_s4[i] <= 40'(ro_s3[i][0]) + 40'(ro_s3[i][1]) + 40'(ro_s3[i][2]);
			end
			fz_s4 <= fz_s3;
			pz_s4 <= pz_s3;
		end
	end

	// stage 5: depth below the limit
	assign cz      = 41'(pz_s4) + 41'(o_s4[2]);
	assign lim_ext = signed'({11'd0, lim_q});
	assign dd      = lim_ext - 42'(cz);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s5.valid <= v_s4;
			ctl_s5.above <= 42'(cz) > lim_ext;
			ctl_s5.full  <= dd >= signed'({10'd0, lim_q, 1'b0});
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s5  <= dd[31:0];
			fz_s5 <= fz_s4;
			o_s5  <= o_s4;
		end
	end

	bwr_scale_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (ctl_s5),
		.d_in    (d_s5),
		.lim     (lim_q),
		.ctl_out (ctl_d),
		.scale   (scale_d)
	);

	for (genvar k = 1; k <= bwr_pkg::DIV_STEPS; k++) begin : g_side
		if (k == 1) begin : g_head
			always_ff @(posedge clk) begin
				if (en) begin
					fz_dly_s[k] <= fz_s5;
					o_dly_s[k]  <= o_s5;
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en) begin
					fz_dly_s[k] <= fz_dly_s[k-1];
					o_dly_s[k]  <= o_dly_s[k-1];
				end
			end
		end
	end

	// stage 6: scaled force
	always_comb begin
		fv[0] = 39'(afx_q);
		fv[1] = 39'(afy_q);
		fv[2] = fz_dly_s[bwr_pkg::DIV_STEPS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				v_f_s6[i] <= ctl_d.full ? 40'(fv[i]) : bwr_pkg::mul_scale(fv[i], scale_d);
			end
			o_s6 <= o_dly_s[bwr_pkg::DIV_STEPS];
		end
	end

	// stage 7: force saturation
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			fsat[i] = bwr_pkg::sat32(57'(v_f_s6[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				f_s7[i] <= fsat[i].val;
			end
			clip_s7 <= fsat[0].clip || fsat[1].clip || fsat[2].clip;
			o_s7    <= o_s6;
		end
	end

	// stage 8: moment products
	always_ff @(posedge clk) begin
		if (en) begin
			mt_s8[0] <= bwr_pkg::mul_mom(o_s7[1], f_s7[2]);
			mt_s8[1] <= bwr_pkg::mul_mom(o_s7[2], f_s7[1]);
			mt_s8[2] <= bwr_pkg::mul_mom(o_s7[2], f_s7[0]);
			mt_s8[3] <= bwr_pkg::mul_mom(o_s7[0], f_s7[2]);
			mt_s8[4] <= bwr_pkg::mul_mom(o_s7[0], f_s7[1]);
			mt_s8[5] <= bwr_pkg::mul_mom(o_s7[1], f_s7[0]);
			f_s8     <= f_s7;
			clip_s8  <= clip_s7;
		end
	end

	// stage 9: moment differences and output register
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			msat[i] = bwr_pkg::sat32(57'(mt_s8[2*i]) - 57'(mt_s8[2*i+1]));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (lim_q == '0) begin
				f_s9      <= '{default: '0};
				m_s9      <= '{default: '0};
				status_s9 <= bwr_pkg::ST_LIMIT_ZERO;
			end else begin
				f_s9 <= f_s8;
				for (int i = 0; i < 3; i++) begin
					m_s9[i] <= msat[i].val;
				end
				if (clip_s8 || msat[0].clip || msat[1].clip || msat[2].clip) begin
					status_s9 <= bwr_pkg::ST_SAT;
				end else begin
					status_s9 <= bwr_pkg::ST_OK;
				end
			end
		end
	end

	assign force_x  = f_s9[0];
	assign force_y  = f_s9[1];
	assign force_z  = f_s9[2];
	assign moment_x = m_s9[0];
	assign moment_y = m_s9[1];
	assign moment_z = m_s9[2];
	assign status   = status_s9;

	`BWR_ASSERT_NXT(a_accept_enters, in_valid && !in_stall, v_s1, "accepted transaction lost at entry")
	`BWR_ASSERT_IMP(a_limit_zero_clears, out_valid && (status == bwr_pkg::ST_LIMIT_ZERO), force_x == '0 && force_y == '0 && force_z == '0 && moment_x == '0 && moment_y == '0 && moment_z == '0, "zero limit result not cleared")
	`BWR_ASSERT_IMP(a_sat_needs_limit, out_valid && (status == bwr_pkg::ST_SAT), lim_q != '0, "saturation flagged with zero limit")

endmodule
